// ===== rtl/nsr_pkg.sv =====
// Shared constants for the Newton square root core.
package nsr_pkg;

   localparam int DATA_W    = 32;                // Q16.16 word
   localparam int FRAC_W    = 16;                // fraction bits
   localparam int QUOT_W    = DATA_W + FRAC_W;   // dividend / quotient width
   localparam int DIV_CNT_W = $clog2(QUOT_W);    // divide step counter
   localparam int MAX_ITER  = 32;                // Newton update cap
   localparam int ITER_W    = 7;                 // holds 0..127

   localparam logic [DATA_W-1:0] TOL_RESET = DATA_W'(1);

endpackage

// ===== rtl/newton_square_root_core.sv =====
// Newton-Raphson square root core, unsigned Q16.16, serial divider inside.
//
// Usage:
//   Request: drive req_radicand and raise start while busy is low; the
//   request is taken at that clock edge and busy rises on the next cycle.
//   Result: rsp_strobe is high for exactly one cycle with rsp_root,
//   rsp_iterations_used and rsp_converged. The receiver cannot stall; the
//   result is shown once and busy is already low in that cycle, so a new
//   request may be issued right then.
//   Config: csr_write_data is taken into the tolerance register at any edge
//   with csr_write_enable high. Write it only while busy is low.
// Operation:
//   Every Newton update runs one restoring divide of a 48-bit dividend by
//   the 32-bit guess, one quotient bit per cycle; an update is a check,
//   the divide and an average. At most MAX_ITER updates run per request.
//   Zero radicand returns with zero updates.
// Reset: synchronous, active high; the core goes idle, no result is
//   pending and the tolerance returns to 1 (one Q16.16 LSB).
module newton_square_root_core
   import nsr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [DATA_W-1:0] req_radicand,
   input  logic              csr_write_enable,
   input  logic [DATA_W-1:0] csr_write_data,
   output logic              rsp_strobe,
   output logic [DATA_W-1:0] rsp_root,
   output logic [ITER_W-1:0] rsp_iterations_used,
   output logic              rsp_converged
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [DATA_W-1:0]    tol_ff, tol_in;
   logic [DATA_W-1:0]    radicand_ff, radicand_in;
   logic [DATA_W-1:0]    guess_ff, guess_in;
   logic [DATA_W-1:0]    prev_ff, prev_in;
   logic [ITER_W-1:0]    iter_ff, iter_in;
   logic [QUOT_W-1:0]    quot_ff, quot_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 strobe_ff, strobe_in;
   logic                 conv_ff, conv_in;

   // change between guesses
   logic [DATA_W-1:0] diff;
   logic              within_tol;
   logic              at_cap;

   // divider step
   logic [DATA_W:0]   rem_shift;
   logic [DATA_W:0]   trial;
   logic              fits;

   // averaging
   logic [QUOT_W:0]   sum;
   logic [QUOT_W-1:0] half;
   logic [DATA_W-1:0] next_guess;

   assign diff       = (guess_ff >= prev_ff) ? (guess_ff - prev_ff) : (prev_ff - guess_ff);
   assign within_tol = (diff <= tol_ff);
   assign at_cap     = (iter_ff == ITER_W'(MAX_ITER));

   // restoring division: shift in next dividend bit, subtract guess if it fits
   assign rem_shift = {rem_ff, quot_ff[QUOT_W-1]};
   assign fits      = (rem_shift >= {1'b0, guess_ff});
   assign trial     = rem_shift - {1'b0, guess_ff};

   // (g + q) / 2 at full width, saturate to 32 bits
   assign sum  = {{(QUOT_W-DATA_W+1){1'b0}}, guess_ff} + {1'b0, quot_ff};
   assign half = sum[QUOT_W:1];

   always_comb begin
      if (guess_ff == '0) begin
         next_guess = '1;                      // zero divisor guard
      end else if (|half[QUOT_W-1:DATA_W]) begin
         next_guess = '1;
      end else begin
         next_guess = half[DATA_W-1:0];
      end
   end

   always_comb begin
      state_in    = state_ff;
      tol_in      = csr_write_enable ? csr_write_data : tol_ff;
      radicand_in = radicand_ff;
      guess_in    = guess_ff;
      prev_in     = prev_ff;
      iter_in     = iter_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      strobe_in   = 1'b0;
      conv_in     = conv_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               radicand_in = req_radicand;
               guess_in    = req_radicand;
               prev_in     = '0;
               iter_in     = '0;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (within_tol || at_cap) begin
               conv_in   = within_tol;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               prev_in  = guess_ff;
               quot_in  = {radicand_ff, FRAC_W'(0)};
               rem_in   = '0;
               cnt_in   = DIV_CNT_W'(QUOT_W - 1);
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            quot_in = {quot_ff[QUOT_W-2:0], fits};
            rem_in  = fits ? trial[DATA_W-1:0] : rem_shift[DATA_W-1:0];
            cnt_in  = cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            guess_in = next_guess;
            iter_in  = iter_ff + ITER_W'(1);
            state_in = ST_CHECK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tol_ff    <= TOL_RESET;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tol_ff    <= tol_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      radicand_ff <= radicand_in;
      guess_ff    <= guess_in;
      prev_ff     <= prev_in;
      iter_ff     <= iter_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      conv_ff     <= conv_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_strobe          = strobe_ff;
   assign rsp_root            = guess_ff;
   assign rsp_iterations_used = iter_ff;
   assign rsp_converged       = conv_ff;

endmodule

// ===== rtl/nsr_checker.sv =====
// Port-level checks for the Newton square root core, bound to the core module.
module nsr_checker
   import nsr_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input logic [ITER_W-1:0] rsp_iterations_used,
   input logic              rsp_converged
);

   // accepted request keeps the core busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after request");

   // result shows only when the core is idle, and never twice in a row
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy ##1 !rsp_strobe)
      else $error("result strobe while busy or repeated");

   // no convergence only when the update cap was hit
   a_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_converged |-> rsp_iterations_used == ITER_W'(MAX_ITER))
      else $error("unconverged result below iteration cap");

   // update count never exceeds the cap
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_iterations_used <= ITER_W'(MAX_ITER))
      else $error("iteration count above cap");

endmodule

bind newton_square_root_core nsr_checker u_nsr_checker (.*);

// ===== sim/tb_newton_square_root_core.sv =====
// Testbench for newton_square_root_core: directed and random requests checked by a scoreboard.
`timescale 1ns / 100ps

module tb_newton_square_root_core;
   import nsr_pkg::*;

   // Run shape: a directed list under the reset tolerance, then one random
   // phase per tolerance setting, each opened by a write while the core idles.
   localparam int N_PHASES     = 7;
   localparam int PHASE_ITEMS  = 215;
   localparam int RANDOM_ITEMS = N_PHASES * PHASE_ITEMS;
   localparam int N_DIRECTED   = 16;

   // Slowest request: MAX_ITER updates, plus a margin for sender gaps;
   // taken three times over for every request in the run.
   localparam int  WORST_LATENCY = 50 * MAX_ITER + 2;
   localparam longint CYCLE_LIMIT =
      longint'(N_DIRECTED + RANDOM_ITEMS) * (WORST_LATENCY + 100) * 3;

   // One expected (or observed) response.
   typedef struct packed {
      logic [DATA_W-1:0] root;
      logic [ITER_W-1:0] iterations_used;
      logic              converged;
   } root_result_type;

   // Scoreboard: predicts the response of every accepted request and checks
   // responses in order against those predictions.
   class sqrt_scoreboard;
      logic [DATA_W-1:0] tolerance;
      root_result_type   pending_roots[$];
      int unsigned       failures;

      function new();
         tolerance = TOL_RESET;
         failures  = 0;
      endfunction

      function logic [DATA_W-1:0] guess_change(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
         return (a >= b) ? a - b : b - a;
      endfunction

      // Newton iteration in Q16.16, change tested before every update and
      // once more after the cap.
      function root_result_type predict_root(logic [DATA_W-1:0] radicand);
         root_result_type   res;
         logic [DATA_W-1:0] guess;
         logic [DATA_W-1:0] prior;
         logic [63:0]       quot;
         logic [63:0]       avg;
         int unsigned       n;
         bit                done;
         guess = radicand;
         prior = '0;
         n     = 0;
         done  = 1'b0;
         while (n < MAX_ITER) begin
            if (guess_change(guess, prior) <= tolerance) begin
               done = 1'b1;
               break;
            end
            prior = guess;
            if (guess == '0) begin
               guess = '1;
            end else begin
               quot  = ({32'b0, radicand} << FRAC_W) / {32'b0, guess};
               avg   = ({32'b0, guess} + quot) >> 1;
               guess = (avg > 64'h0000_0000_FFFF_FFFF) ? '1 : avg[DATA_W-1:0];
            end
            n++;
         end
         if (!done && guess_change(guess, prior) <= tolerance)
            done = 1'b1;
         res.root            = guess;
         res.iterations_used = ITER_W'(n);
         res.converged       = done;
         return res;
      endfunction

      function void note_request(logic [DATA_W-1:0] radicand);
         pending_roots.push_back(predict_root(radicand));
      endfunction

      function void check_result(root_result_type got);
         root_result_type want;
         if (pending_roots.size() == 0) begin
            $error("unexpected response: root %h iterations_used %0d converged %0d",
                   got.root, got.iterations_used, got.converged);
            failures++;
            return;
         end
         want = pending_roots.pop_front();
         if (got.root !== want.root) begin
            $error("root: expected %h, actual %h", want.root, got.root);
            failures++;
         end
         if (got.iterations_used !== want.iterations_used) begin
            $error("iterations_used: expected %0d, actual %0d",
                   want.iterations_used, got.iterations_used);
            failures++;
         end
         if (got.converged !== want.converged) begin
            $error("converged: expected %0d, actual %0d", want.converged, got.converged);
            failures++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [DATA_W-1:0] req_radicand = '0;
   logic              csr_write_enable = 1'b0;
   logic [DATA_W-1:0] csr_write_data = '0;
   logic              rsp_strobe;
   logic [DATA_W-1:0] rsp_root;
   logic [ITER_W-1:0] rsp_iterations_used;
   logic              rsp_converged;

   sqrt_scoreboard board = new();
   int             idle_pct = 0;    // chance per cycle that the sender holds start low
   longint         cycle_count = 0;

   newton_square_root_core dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_radicand        (req_radicand),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_strobe          (rsp_strobe),
      .rsp_root            (rsp_root),
      .rsp_iterations_used (rsp_iterations_used),
      .rsp_converged       (rsp_converged)
   );

   always #5 clock = ~clock;

   // Response monitor: the strobe lasts one cycle and cannot be stalled, so
   // every strobed cycle is a response.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         board.check_result('{rsp_root, rsp_iterations_used, rsp_converged});
   end

   // Watchdog: a hung core or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Present one request. start is re-rolled every cycle while waiting, so
   // gaps land anywhere, including the edge where busy drops. Called and
   // returns at a rising edge; start is left high so that a back-to-back
   // request keeps it high without a second assignment in the same step.
   task automatic send_request(input logic [DATA_W-1:0] radicand);
      req_radicand <= radicand;
      forever begin
         start <= ($urandom_range(0, 99) >= idle_pct);
         @(posedge clock);
         if (start && !busy)
            break;
      end
      board.note_request(radicand);
   endtask

   // Hold off the sender until every predicted response has come back.
   task automatic drain_results();
      start <= 1'b0;
      while (board.pending_roots.size() != 0)
         @(posedge clock);
   endtask

   // Only called while the core is idle.
   task automatic write_tolerance(input logic [DATA_W-1:0] tol);
      csr_write_enable <= 1'b1;
      csr_write_data   <= tol;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.tolerance = tol;
   endtask

   initial begin
      logic [DATA_W-1:0] directed[N_DIRECTED];
      logic [DATA_W-1:0] tol;
      logic [DATA_W-1:0] radicand;
      int                sent;

      // Field extremes, zero radicand, values around 1.0, exact squares
      // (4.0, 9.0) and alternating bit patterns.
      directed = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                   32'h0000_0100, 32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001,
                   32'h0004_0000, 32'h0009_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part runs with the reset tolerance of one LSB.
      foreach (directed[i])
         send_request(directed[i]);

      sent = 0;
      for (int phase = 0; phase < N_PHASES; phase++) begin
         drain_results();
         // Tolerance zero forces the cap whenever the guess toggles; all ones
         // makes every request finish with no update.
         case (phase)
            0:       tol = 32'h0000_0000;
            1:       tol = 32'hFFFF_FFFF;
            2:       tol = 32'h0000_0001;
            3:       tol = 32'h0000_0100;
            4:       tol = $urandom_range(0, 15);
            5:       tol = 32'h0001_0000;
            default: tol = $urandom;
         endcase
         write_tolerance(tol);

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // Sender idles 18%, then 64%, then never.
            idle_pct = (sent < RANDOM_ITEMS / 3) ? 18 :
                       (sent < 2 * RANDOM_ITEMS / 3) ? 64 : 0;
            // Pause once mid-phase until the core has fully drained.
            if (phase == 3 && k == PHASE_ITEMS / 2)
               drain_results();

            // Mix magnitudes: full range, random scale, tiny, near 1.0, near full scale, ends.
            case ($urandom_range(0, 5))
               0:       radicand = $urandom;
               1:       radicand = $urandom >> $urandom_range(0, 31);
               2:       radicand = $urandom_range(0, 255);
               3:       radicand = 32'h0001_0000 + $urandom_range(0, 64) - 32;
               4:       radicand = $urandom | 32'hFFFF_0000;
               default: radicand = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            endcase
            send_request(radicand);
            sent++;
         end
      end

      drain_results();
      // Let a stray response surface before the verdict.
      repeat (WORST_LATENCY) @(posedge clock);

      if (board.failures == 0 && board.pending_roots.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
